[design/spi_master_shifter_top_defines.svh]
// ----------------------------------------------------------------------------
// SPI master shifter assertion macros
// Concurrent assertion helpers shared by the shifter modules.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_SHIFTER_TOP_DEFINES_SVH
`define SPI_MASTER_SHIFTER_TOP_DEFINES_SVH

`ifndef SYNTH

// Plain property checked on every clock edge outside reset.
`define SPIMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("spims assertion failed");

// Same-cycle implication.
`define SPIMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spims implication failed");

// Next-cycle implication.
`define SPIMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spims next-cycle implication failed");

`else

`define SPIMS_ASSERT(label, prop)
`define SPIMS_ASSERT_IMPL(label, ante, cons)
`define SPIMS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/spims_pkg.sv]
// ----------------------------------------------------------------------------
// SPI master shifter package
// Types and constants shared by the shifter modules.
// ----------------------------------------------------------------------------
package spims_pkg;

  // Fixed widths of the transfer fields.
  localparam int unsigned WordW     = 32;
  localparam int unsigned BitsW     = 6;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxBitsDefault  = 32;
  localparam int unsigned DivWidthDefault = 16;

  // Register reset values.
  localparam logic [BitsW-1:0] WordBitsReset = BitsW'(8);
  localparam logic [HalfW-1:0] HalfReset     = HalfW'(1);

  typedef enum logic [CfgAddrW-1:0] {
    REG_CPOL      = 3'd0,
    REG_CPHA      = 3'd1,
    REG_LSB_FIRST = 3'd2,
    REG_WORD_BITS = 3'd3,
    REG_HALF      = 3'd4
  } spims_reg_e;

  typedef struct packed {
    logic             func;
    logic [WordW-1:0] tx_word;
    logic             miso_level;
  } spims_in_t;

  typedef struct packed {
    logic             sck_level;
    logic             mosi_level;
    logic             busy_res;
    logic             done_res;
    logic [WordW-1:0] rx_word;
  } spims_out_t;

  // Raw register contents handed to the engine.
  typedef struct packed {
    logic             cpol;
    logic             cpha;
    logic             lsb_first;
    logic [BitsW-1:0] word_bits;
    logic [HalfW-1:0] half_period;
  } spims_cfg_t;

endpackage

[design/spims_cfg.sv]
// ----------------------------------------------------------------------------
// SPI master shifter configuration registers
// Decodes the write port into the mode, length and divider registers.
// ----------------------------------------------------------------------------
module spims_cfg
  import spims_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output spims_cfg_t          cfg_o
);

  spims_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (spims_reg_e'(cfg_idx_i))
        REG_CPOL:      cfg_d.cpol        = cfg_data_i[0];
        REG_CPHA:      cfg_d.cpha        = cfg_data_i[0];
        REG_LSB_FIRST: cfg_d.lsb_first   = cfg_data_i[0];
        REG_WORD_BITS: cfg_d.word_bits   = cfg_data_i[BitsW-1:0];
        REG_HALF:      cfg_d.half_period = cfg_data_i[HalfW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpol        <= 1'b0;
      cfg_q.cpha        <= 1'b0;
      cfg_q.lsb_first   <= 1'b0;
      cfg_q.word_bits   <= WordBitsReset;
      cfg_q.half_period <= HalfReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/spims_engine.sv]
// ----------------------------------------------------------------------------
// SPI master shifter engine
// Advances the serial clock, shift registers and counters by one tick.
// ----------------------------------------------------------------------------
`include "spi_master_shifter_top_defines.svh"

module spims_engine
  import spims_pkg::*;
#(
  parameter int unsigned MAX_BITS  = MaxBitsDefault,
  parameter int unsigned DIV_WIDTH = DivWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spims_cfg_t cfg_i,
  input  logic       fire_i,
  input  spims_in_t  item_i,
  output spims_out_t res_o
);

  localparam int unsigned BitLim = (MAX_BITS < WordW) ? MAX_BITS : WordW;
  localparam int unsigned BcW    = $clog2(BitLim + 1);
  localparam int unsigned HcW    = (DIV_WIDTH > HalfW) ? DIV_WIDTH : HalfW;

  logic [WordW-1:0]     tx_q, tx_d, rx_q, rx_d;
  logic [BcW-1:0]       bc_q, bc_d, bc_inc;
  logic [DIV_WIDTH-1:0] tick_q, tick_d;
  logic                 sh_q, sh_d, sck_q, sck_d, active_q, active_d;

  logic [BitsW-1:0]     n_bits, idx;
  logic [WordW-1:0]     mask;
  logic [HcW-1:0]       half_ext, half_top, half_eff;
  logic                 half_end, done, mosi, lead_level;
  logic [WordW-1:0]     rx_out;

  // Effective word length and divider, clamped to the supported range.
  always_comb begin
    if (cfg_i.word_bits == '0) begin
      n_bits = BitsW'(1);
    end else if (cfg_i.word_bits > BitsW'(BitLim)) begin
      n_bits = BitsW'(BitLim);
    end else begin
      n_bits = cfg_i.word_bits;
    end
    mask     = {WordW{1'b1}} >> (BitsW'(WordW) - n_bits);
    half_ext = HcW'(cfg_i.half_period);
    half_top = HcW'({DIV_WIDTH{1'b1}});
    if (half_ext == '0) begin
      half_eff = HcW'(1);
    end else if (half_ext > half_top) begin
      half_eff = half_top;
    end else begin
      half_eff = half_ext;
    end
  end

  assign half_end   = ((HcW + 1)'(tick_q) + (HcW + 1)'(1)) >= (HcW + 1)'(half_eff);
  assign bc_inc     = bc_q + BcW'(1);
  assign lead_level = cfg_i.cpha ? ~cfg_i.cpol : cfg_i.cpol;

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bc_d     = bc_q;
    tick_d   = tick_q;
    sh_d     = sh_q;
    sck_d    = sck_q;
    active_d = active_q;
    done     = 1'b0;
    rx_out   = '0;
    if (fire_i) begin
      if (active_q) begin
        if (half_end) begin
          tick_d = '0;
          if (!sh_q) begin
            // Capture edge: toggle the clock and shift MISO in.
            sck_d = ~sck_q;
            if (cfg_i.lsb_first) begin
              rx_d = (rx_q >> 1) | (WordW'(item_i.miso_level) << (n_bits - BitsW'(1)));
            end else begin
              rx_d = ((rx_q << 1) | WordW'(item_i.miso_level)) & mask;
            end
            sh_d = 1'b1;
          end else begin
            sh_d = 1'b0;
            if (BitsW'(bc_inc) >= n_bits) begin
              active_d = 1'b0;
              done     = 1'b1;
              rx_out   = rx_q & mask;
              sck_d    = cfg_i.cpol;
              bc_d     = '0;
            end else begin
              bc_d  = bc_inc;
              sck_d = lead_level;
            end
          end
        end else begin
          tick_d = tick_q + DIV_WIDTH'(1);
        end
      end else if (item_i.func) begin
        tx_d     = item_i.tx_word & mask;
        rx_d     = '0;
        bc_d     = '0;
        tick_d   = '0;
        sh_d     = 1'b0;
        active_d = 1'b1;
        sck_d    = lead_level;
      end
    end
  end

  // MOSI reflects the bit that is being driven after this tick.
  always_comb begin
    idx  = cfg_i.lsb_first ? BitsW'(bc_d) : (n_bits - BitsW'(1) - BitsW'(bc_d));
    mosi = 1'b0;
    if (active_d && (BitsW'(bc_d) < n_bits)) begin
      mosi = tx_d[idx[4:0]];
    end
  end

  assign res_o.sck_level  = active_d ? sck_d : cfg_i.cpol;
  assign res_o.mosi_level = mosi;
  assign res_o.busy_res   = active_d;
  assign res_o.done_res   = done;
  assign res_o.rx_word    = rx_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= '0;
      rx_q     <= '0;
      bc_q     <= '0;
      tick_q   <= '0;
      sh_q     <= 1'b0;
      sck_q    <= 1'b0;
      active_q <= 1'b0;
    end else begin
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      bc_q     <= bc_d;
      tick_q   <= tick_d;
      sh_q     <= sh_d;
      sck_q    <= sck_d;
      active_q <= active_d;
    end
  end

  // Idle engine keeps its counters cleared so the next start is clean.
  `SPIMS_ASSERT_IMPL(a_idle_clear, !active_q, (bc_q == '0) && (tick_q == '0) && !sh_q)
  `SPIMS_ASSERT_NEXT(a_done_idle, fire_i && done, !active_q)
  `SPIMS_ASSERT_NEXT(a_start_busy, fire_i && !active_q && item_i.func, active_q && !sh_q)

endmodule

[design/spims_skid.sv]
// ----------------------------------------------------------------------------
// SPI master shifter result buffer
// Output register with a skid entry so a new transfer is taken while a
// result waits.
// ----------------------------------------------------------------------------
`include "spi_master_shifter_top_defines.svh"

module spims_skid
  import spims_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  spims_out_t data_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output spims_out_t out_data_o
);

  spims_out_t main_q, main_d, skid_q, skid_d;
  logic       main_vld_q, main_vld_d, skid_vld_q, skid_vld_d, pop;

  assign pop = main_vld_q && !out_stall_i;

  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (push_i) begin
      // A push only happens while the skid entry is empty.
      if (!main_vld_q || pop) begin
        main_d     = data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  `SPIMS_ASSERT(a_skid_behind_main, !skid_vld_q || main_vld_q)

endmodule

[design/spi_master_shifter_top.sv]
// A result is registered into the output buffer when its tick transfer is accepted.
// Throughput: one tick transfer per cycle while not stalled; the engine state
// updates in the accepting cycle and the result goes into a two-entry output
// buffer. Input stall rises only when both buffer entries hold unread results.
// Reset (rst_ni low, asynchronous) idles the engine and loads the default
// registers: mode 0, MSB first, 8-bit words, half period of one tick.
// ----------------------------------------------------------------------------
// SPI master shifter top level
// SPI master shift engine with configurable mode, bit order and word length.
// ----------------------------------------------------------------------------
module spi_master_shifter_top
  import spims_pkg::*;
#(
  parameter int unsigned MAX_BITS  = MaxBitsDefault,
  parameter int unsigned DIV_WIDTH = DivWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spims_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spims_out_t          out_data_o
);

  spims_cfg_t cfg;
  spims_out_t res;
  logic       fire, full;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  spims_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  spims_engine #(
    .MAX_BITS  (MAX_BITS),
    .DIV_WIDTH (DIV_WIDTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (in_data_i),
    .res_o  (res)
  );

  spims_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI master shifter testbench
// Streams tick transfers into the shift engine under random back-pressure on
// both channels and compares every output transfer, field by field, with the
// line levels that a cycle-free model of the engine gives for the same ticks.
// ----------------------------------------------------------------------------
module tb_top
  import spims_pkg::*;
;

  class spi_line_tracker;
    // Register copy.
    logic             cpol;
    logic             cpha;
    logic             lsb;
    logic [BitsW-1:0] wbits;
    logic [HalfW-1:0] half;
    // Engine copy.
    logic [WordW-1:0] tx_sh;
    logic [WordW-1:0] rx_sh;
    logic [BitsW-1:0] bit_cnt;
    logic [HalfW-1:0] tick_cnt;
    logic             second_half;
    logic             sck;
    logic             active;

    spims_out_t levels_q[$];
    int errors;
    int shown;
    int ticks;
    int words;
    int writes;

    function new();
      cpol = 1'b0;
      cpha = 1'b0;
      lsb = 1'b0;
      wbits = WordBitsReset;
      half = HalfReset;
      tx_sh = '0;
      rx_sh = '0;
      bit_cnt = '0;
      tick_cnt = '0;
      second_half = 1'b0;
      sck = 1'b0;
      active = 1'b0;
      errors = 0;
      shown = 0;
      ticks = 0;
      words = 0;
      writes = 0;
    endfunction

    function int pending();
      return levels_q.size();
    endfunction

    function logic [WordW-1:0] word_mask(logic [BitsW-1:0] n);
      return (n >= BitsW'(32)) ? '1 : ((WordW'(1) << n) - WordW'(1));
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_CPOL:      cpol = data[0];
        REG_CPHA:      cpha = data[0];
        REG_LSB_FIRST: lsb = data[0];
        REG_WORD_BITS: wbits = data[BitsW-1:0];
        REG_HALF:      half = data[HalfW-1:0];
        default: ;
      endcase
      if (!active) sck = cpol;
      writes++;
    endfunction

    // Advances the engine by one accepted tick and queues the line levels it shows.
    function void note_tick(spims_in_t t);
      logic [BitsW-1:0] n;
      logic [HalfW-1:0] h;
      logic [HalfW:0]   tick_nxt;
      logic [BitsW-1:0] idx;
      spims_out_t       r;
      n = wbits;
      if (n < BitsW'(1)) n = BitsW'(1);
      if (n > BitsW'(32)) n = BitsW'(32);
      h = (half == '0) ? HalfW'(1) : half;
      r = '0;
      ticks++;
      if (active) begin
        tick_nxt = {1'b0, tick_cnt} + (HalfW + 1)'(1);
        if (tick_nxt >= {1'b0, h}) begin
          tick_cnt = '0;
          if (!second_half) begin
            sck = ~sck;
            if (lsb) begin
              rx_sh = (rx_sh >> 1) |
                      (WordW'(t.miso_level) << ((n - BitsW'(1)) & BitsW'(31)));
            end else begin
              rx_sh = ((rx_sh << 1) | WordW'(t.miso_level)) & word_mask(n);
            end
            second_half = 1'b1;
          end else begin
            second_half = 1'b0;
            bit_cnt = bit_cnt + BitsW'(1);
            if (bit_cnt >= n) begin
              active = 1'b0;
              r.done_res = 1'b1;
              r.rx_word = rx_sh & word_mask(n);
              sck = cpol;
              bit_cnt = '0;
              words++;
            end else begin
              sck = cpha ? ~cpol : cpol;
            end
          end
        end else begin
          tick_cnt = tick_nxt[HalfW-1:0];
        end
      end else if (t.func) begin
        tx_sh = t.tx_word & word_mask(n);
        rx_sh = '0;
        bit_cnt = '0;
        tick_cnt = '0;
        second_half = 1'b0;
        active = 1'b1;
        sck = cpha ? ~cpol : cpol;
      end
      r.sck_level = active ? sck : cpol;
      r.busy_res = active;
      // A bit count at or past a shortened word length drives the data line low.
      if (active && bit_cnt < n) begin
        idx = lsb ? bit_cnt : (n - BitsW'(1) - bit_cnt);
        r.mosi_level = tx_sh[idx[4:0]];
      end
      levels_q.push_back(r);
    endfunction

    function void flag(string field, logic [WordW-1:0] exp, logic [WordW-1:0] got);
      errors++;
      if (shown < 40) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, got);
      end else if (shown == 40) begin
        $display("%0t: further mismatches not shown", $time);
      end
      shown++;
    endfunction

    function void check_levels(spims_out_t got);
      spims_out_t exp;
      if (levels_q.size() == 0) begin
        flag("unexpected transfer", '0, got.rx_word);
        return;
      end
      exp = levels_q.pop_front();
      if (got.sck_level !== exp.sck_level)
        flag("sck_level", WordW'(exp.sck_level), WordW'(got.sck_level));
      if (got.mosi_level !== exp.mosi_level)
        flag("mosi_level", WordW'(exp.mosi_level), WordW'(got.mosi_level));
      if (got.busy_res !== exp.busy_res)
        flag("busy_res", WordW'(exp.busy_res), WordW'(got.busy_res));
      if (got.done_res !== exp.done_res)
        flag("done_res", WordW'(exp.done_res), WordW'(got.done_res));
      if (got.rx_word !== exp.rx_word) flag("rx_word", exp.rx_word, got.rx_word);
    endfunction
  endclass

  localparam int unsigned CycleLimit = 1000000;
  // An index with no register behind it; a write there must change nothing.
  localparam logic [CfgAddrW-1:0] RegSpare = CfgAddrW'(7);

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  spims_in_t           in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  spims_out_t          out_data_o;

  spi_line_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int unsigned cycles;

  spi_master_shifter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 32'd1;
    if (cycles >= CycleLimit) begin
      $display("FAIL spi_master_shifter_top");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_levels(out_data_o);
  end

  task automatic drive_tick(spims_in_t t);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_tick(t);
  endtask

  task automatic random_ticks(int count, int start_pct);
    spims_in_t t;
    for (int i = 0; i < count; i++) begin
      t.func = ($urandom_range(0, 99) < start_pct);
      t.tx_word = $urandom;
      t.miso_level = 1'($urandom_range(0, 1));
      drive_tick(t);
    end
  endtask

  task automatic start_word();
    spims_in_t t;
    t.func = 1'b1;
    t.tx_word = $urandom;
    t.miso_level = 1'($urandom_range(0, 1));
    drive_tick(t);
  endtask

  // Drops valid and lets every result in flight arrive before registers move.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Unused upper data bits are randomised; the block must ignore them.
  task automatic set_mode(logic cpol, logic cpha, logic lsb, logic [BitsW-1:0] bits,
                          logic [HalfW-1:0] half);
    quiesce();
    write_cfg(REG_CPOL, {15'($urandom), cpol});
    write_cfg(REG_CPHA, {15'($urandom), cpha});
    write_cfg(REG_LSB_FIRST, {15'($urandom), lsb});
    write_cfg(REG_WORD_BITS, {10'($urandom), bits});
    write_cfg(REG_HALF, half);
  endtask

  initial begin
    spims_in_t t;
    tracker = new();
    cycles = 0;
    send_idle_pct = 28;
    recv_idle_pct = 66;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CPOL;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset mode with an all-ones word, then starts on every tick so
    // that starts land while busy and on the tick that ends the word.
    t.func = 1'b1;
    t.tx_word = '1;
    t.miso_level = 1'b1;
    drive_tick(t);
    for (int i = 0; i < 18; i++) begin
      t.func = 1'b1;
      t.tx_word = '0;
      t.miso_level = i[0];
      drive_tick(t);
    end
    t.func = 1'b0;
    t.miso_level = 1'b0;
    drive_tick(t);
    random_ticks(60, 6);

    set_mode(1'b1, 1'b1, 1'b1, 6'd32, 16'd2);
    random_ticks(70, 4);
    set_mode(1'b0, 1'b1, 1'b0, 6'd1, 16'd1);
    write_cfg(RegSpare, 16'($urandom));
    random_ticks(60, 10);
    // Zero length and zero half period both act as one.
    set_mode(1'b1, 1'b0, 1'b1, 6'd0, 16'd0);
    random_ticks(60, 10);

    send_idle_pct = 66;
    recv_idle_pct = 28;
    // Lengths above the word width saturate.
    set_mode(1'b0, 1'b0, 1'b1, 6'd63, 16'd3);
    random_ticks(100, 3);
    set_mode(1'b1, 1'b1, 1'b0, 6'd33, 16'd1);
    random_ticks(80, 5);
    // Shorten the word under a transfer that is already past the new length.
    set_mode(1'b0, 1'b0, 1'b0, 6'd32, 16'd4);
    start_word();
    random_ticks(40, 0);
    quiesce();
    write_cfg(REG_WORD_BITS, {10'($urandom), 6'd3});
    random_ticks(60, 5);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // One whole bit at a long half period.
    set_mode(1'b0, 1'b1, 1'b1, 6'd1, 16'd40);
    start_word();
    random_ticks(85, 0);
    // The longest half period cut short in the middle of a bit.
    set_mode(1'b1, 1'b0, 1'b0, 6'd16, 16'hFFFF);
    start_word();
    random_ticks(100, 0);
    quiesce();
    write_cfg(REG_HALF, 16'd1);
    random_ticks(60, 4);
    set_mode(1'b0, 1'b0, 1'b0, 6'd8, 16'd1);
    random_ticks(60, 6);

    quiesce();
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d ticks, %0d completed words and %0d register writes",
             tracker.ticks, tracker.words, tracker.writes);
    $display("across all clock modes, both bit orders and the length and period limits.");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS spi_master_shifter_top");
    end else begin
      $display("FAIL spi_master_shifter_top");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/spims_pkg.sv
design/spims_cfg.sv
design/spims_engine.sv
design/spims_skid.sv
design/spi_master_shifter_top.sv
bench/tb_top.sv
